// ----- design/jtdc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package jtdc_pkg;

    localparam int C_MAX_ARRAY_DIMS = 255;
    localparam int C_MAX_ARG_SLOTS  = 255;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       mode;
        logic       last_byte;
    } t_desc_in;

    typedef struct packed {
        logic [3:0] status;
        logic [3:0] type_kind;
        logic [7:0] array_dim;
        logic [8:0] arg_slots;
        logic [7:0] param_count;
    } t_desc_out;

    // descriptor phases
    localparam logic [2:0] PH_START       = 3'd0;
    localparam logic [2:0] PH_PARAM       = 3'd1;
    localparam logic [2:0] PH_FINAL       = 3'd2;
    localparam logic [2:0] PH_PARAM_ARRAY = 3'd3;
    localparam logic [2:0] PH_PARAM_CLASS = 3'd4;
    localparam logic [2:0] PH_FINAL_ARRAY = 3'd5;
    localparam logic [2:0] PH_FINAL_CLASS = 3'd6;

    // verdicts
    localparam logic [3:0] ST_OK        = 4'd0;
    localparam logic [3:0] ST_TRUNCATED = 4'd1;
    localparam logic [3:0] ST_ILLEGAL   = 4'd2;
    localparam logic [3:0] ST_VOID      = 4'd3;
    localparam logic [3:0] ST_DIMS      = 4'd4;
    localparam logic [3:0] ST_ELEMENT   = 4'd5;
    localparam logic [3:0] ST_TRAILING  = 4'd6;
    localparam logic [3:0] ST_NO_PAREN  = 4'd7;
    localparam logic [3:0] ST_SLOTS     = 4'd8;

    // type kinds
    localparam logic [3:0] K_Z    = 4'd0;
    localparam logic [3:0] K_B    = 4'd1;
    localparam logic [3:0] K_C    = 4'd2;
    localparam logic [3:0] K_S    = 4'd3;
    localparam logic [3:0] K_I    = 4'd4;
    localparam logic [3:0] K_J    = 4'd5;
    localparam logic [3:0] K_F    = 4'd6;
    localparam logic [3:0] K_D    = 4'd7;
    localparam logic [3:0] K_V    = 4'd8;
    localparam logic [3:0] K_REF  = 4'd9;
    localparam logic [3:0] K_NONE = 4'd15;

    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_CLASS  = 8'h4C;
    localparam logic [7:0] CH_Z      = 8'h5A;
    localparam logic [7:0] CH_B      = 8'h42;
    localparam logic [7:0] CH_C      = 8'h43;
    localparam logic [7:0] CH_S      = 8'h53;
    localparam logic [7:0] CH_I      = 8'h49;
    localparam logic [7:0] CH_J      = 8'h4A;
    localparam logic [7:0] CH_F      = 8'h46;
    localparam logic [7:0] CH_D      = 8'h44;
    localparam logic [7:0] CH_V      = 8'h56;

    function automatic logic [3:0] kind_of(input logic [7:0] c);
        logic [3:0] k;
        unique case (c)
            CH_Z:    k = K_Z;
            CH_B:    k = K_B;
            CH_C:    k = K_C;
            CH_S:    k = K_S;
            CH_I:    k = K_I;
            CH_J:    k = K_J;
            CH_F:    k = K_F;
            CH_D:    k = K_D;
            CH_V:    k = K_V;
            default: k = K_NONE;
        endcase
        return k;
    endfunction

endpackage

`default_nettype wire

// ----- design/jvm_type_descriptor_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

// JVM field / method type descriptor checker.
// Input channel (i_in_valid / o_in_ready / i_in_data) carries one descriptor
// byte per transfer with its mode and last-byte flag; mode is taken from the
// first byte of each descriptor only.
// Output channel (o_out_valid / i_out_ready / o_out_data) carries one verdict
// per descriptor: at its last byte, or at the first error, after which the
// rest of that descriptor gives no transfer.
// A byte in the input register is parsed, and any verdict it gives is written
// to the output register, once that register is free. Throughput: one byte
// per cycle while the receiver does not stall, set by the combinational
// update of the parse state between the input register and the output register.
// When the receiver stalls, the held verdict blocks the parse stage; the
// input register still takes one more byte, then o_in_ready drops until the
// verdict is transferred.
// Synchronous reset (i_rst_n low) empties both registers and returns the
// parser to the start of a descriptor.
module jvm_type_descriptor_checker
    import jtdc_pkg::*;
#(
    parameter int MAX_ARRAY_DIMS = C_MAX_ARRAY_DIMS,
    parameter int MAX_ARG_SLOTS  = C_MAX_ARG_SLOTS
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_desc_in  i_in_data,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_desc_out      o_out_data
);

    logic       r_in_vld;
    t_desc_in   r_in;
    logic       r_out_vld;
    t_desc_out  r_out;

    logic [2:0] r_phase,   n_phase;
    logic       r_method,  n_method;
    logic [8:0] r_dim,     n_dim;
    logic [8:0] r_slot,    n_slot;
    logic [7:0] r_param,   n_param;
    logic       r_swallow, n_swallow;

    logic       adv;
    logic       emit;
    t_desc_out  res;

    assign adv        = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_in_vld || adv;
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    always_comb begin
        logic [7:0] c;
        logic       last;
        logic       fin;
        logic       do_begin;
        logic       do_array;
        logic       do_cmp;
        logic       ok;
        logic       err;
        logic [3:0] ecode;
        logic [3:0] ck;
        logic [3:0] cdims_k;
        logic [8:0] cdims;
        logic [9:0] sum;

        c        = r_in.char_byte;
        last     = r_in.last_byte;
        fin      = 1'b0;
        do_begin = 1'b0;
        do_array = 1'b0;
        do_cmp   = 1'b0;
        ok       = 1'b0;
        err      = 1'b0;
        ecode    = ST_OK;
        ck       = K_Z;
        cdims    = '0;
        cdims_k  = kind_of(c);
        sum      = '0;

        n_phase   = r_phase;
        n_method  = r_method;
        n_dim     = r_dim;
        n_slot    = r_slot;
        n_param   = r_param;
        n_swallow = r_swallow;
        emit      = 1'b0;
        res       = '0;

        if (r_swallow) begin
            if (last) begin
                n_phase   = PH_START;
                n_method  = 1'b0;
                n_dim     = '0;
                n_slot    = '0;
                n_param   = '0;
                n_swallow = 1'b0;
            end
        end else begin
            unique case (r_phase)
                PH_START: begin
                    n_method = r_in.mode;
                    if (r_in.mode) begin
                        if (c != CH_LPAREN) begin
                            err   = 1'b1;
                            ecode = ST_NO_PAREN;
                        end else begin
                            n_phase = PH_PARAM;
                        end
                    end else begin
                        n_phase  = PH_FINAL;
                        do_begin = 1'b1;
                        fin      = 1'b1;
                    end
                end
                PH_PARAM: begin
                    if (c == CH_RPAREN) begin
                        if (r_slot > 9'(MAX_ARG_SLOTS)) begin
                            err   = 1'b1;
                            ecode = ST_SLOTS;
                        end else begin
                            n_phase = PH_FINAL;
                        end
                    end else begin
                        if (r_param != 8'hFF) begin
                            n_param = r_param + 8'd1;
                        end
                        do_begin = 1'b1;
                    end
                end
                PH_PARAM_ARRAY: do_array = 1'b1;
                PH_FINAL_ARRAY: begin
                    do_array = 1'b1;
                    fin      = 1'b1;
                end
                PH_PARAM_CLASS: begin
                    if (c == CH_SEMI) begin
                        do_cmp = 1'b1;
                        ck     = K_REF;
                        cdims  = r_dim;
                    end
                end
                PH_FINAL_CLASS: begin
                    if (c == CH_SEMI) begin
                        do_cmp = 1'b1;
                        fin    = 1'b1;
                        ck     = K_REF;
                        cdims  = r_dim;
                    end
                end
                default: begin
                    do_begin = 1'b1;
                    fin      = 1'b1;
                end
            endcase

            if (do_begin) begin
                if (cdims_k < K_V) begin
                    do_cmp = 1'b1;
                    ck     = cdims_k;
                    cdims  = '0;
                end else if (cdims_k == K_V) begin
                    if (fin && n_method) begin
                        do_cmp = 1'b1;
                        ck     = K_V;
                        cdims  = '0;
                    end else begin
                        err   = 1'b1;
                        ecode = ST_VOID;
                    end
                end else begin
                    n_dim = '0;
                    if (c == CH_CLASS) begin
                        n_phase = fin ? PH_FINAL_CLASS : PH_PARAM_CLASS;
                    end else if (c == CH_LBRACK) begin
                        n_dim   = 9'd1;
                        n_phase = fin ? PH_FINAL_ARRAY : PH_PARAM_ARRAY;
                    end else begin
                        err   = 1'b1;
                        ecode = ST_ILLEGAL;
                    end
                end
            end

            if (do_array) begin
                if (c == CH_LBRACK) begin
                    if (r_dim != 9'd256) begin
                        n_dim = r_dim + 9'd1;
                    end
                end else if (r_dim > 9'(MAX_ARRAY_DIMS)) begin
                    err   = 1'b1;
                    ecode = ST_DIMS;
                end else if (cdims_k < K_V) begin
                    do_cmp = 1'b1;
                    ck     = K_REF;
                    cdims  = r_dim;
                end else if (c == CH_CLASS) begin
                    n_phase = fin ? PH_FINAL_CLASS : PH_PARAM_CLASS;
                end else begin
                    err   = 1'b1;
                    ecode = ST_ELEMENT;
                end
            end

            if (do_cmp) begin
                if (fin) begin
                    ok = 1'b1;
                end else begin
                    sum = {1'b0, r_slot} + ((ck == K_J || ck == K_D) ? 10'd2 : 10'd1);
                    n_slot  = (sum > 10'd256) ? 9'd256 : sum[8:0];
                    n_phase = PH_PARAM;
                end
            end

            if (ok) begin
                emit       = 1'b1;
                res.status = last ? ST_OK : ST_TRAILING;
            end else if (err) begin
                emit       = 1'b1;
                res.status = ecode;
            end else if (last) begin
                emit       = 1'b1;
                res.status = (n_phase == PH_PARAM && n_slot > 9'(MAX_ARG_SLOTS))
                             ? ST_SLOTS : ST_TRUNCATED;
            end

            if (emit) begin
                if (res.status == ST_OK) begin
                    res.type_kind = ck;
                    res.array_dim = cdims[7:0];
                end
                res.arg_slots   = n_slot;
                res.param_count = n_param;
                n_phase   = PH_START;
                n_method  = 1'b0;
                n_dim     = '0;
                n_slot    = '0;
                n_param   = '0;
                n_swallow = !last;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_phase   <= PH_START;
            r_method  <= 1'b0;
            r_dim     <= '0;
            r_slot    <= '0;
            r_param   <= '0;
            r_swallow <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_vld <= i_in_valid;
            end
            if (adv) begin
                r_out_vld <= emit;
                r_phase   <= n_phase;
                r_method  <= n_method;
                r_dim     <= n_dim;
                r_slot    <= n_slot;
                r_param   <= n_param;
                r_swallow <= n_swallow;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_data;
        end
        if (adv && emit) begin
            r_out <= res;
        end
    end

endmodule

`default_nettype wire
